// ----- src/qlsc_pkg.sv -----
package qlsc_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CNT_W     = 9;
    localparam int WIDE_W    = 192;
    localparam int FRAC_BITS = 40;
    localparam int SX_W      = 20;
    localparam int SX2_W     = 32;
    localparam int SX3_W     = 44;
    localparam int SX4_W     = 56;
    localparam int SY_W      = 20;
    localparam int SXY_W     = 32;
    localparam int SX2Y_W    = 44;
    localparam int ENT_W     = 56;
    localparam int COEF_W    = 64;
    localparam int DCNT_W    = 8;
    localparam int STEP_W    = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [STEP_W-1:0] LAST_STEP       = 4'd8;
    localparam logic [CNT_W-1:0]  FIT_COUNT_RESET = 9'd16;
    localparam logic              ADDR_FIT_COUNT  = 1'b0;
    localparam logic [COEF_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic {
        OP_ACCUM,
        OP_SOLVE
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CNT_W-1:0]    n;
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_SQ,
        ST_ACC_CUBE,
        ST_ACC_SUM,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_DET_END,
        ST_DIV_ABS,
        ST_DIV_PREP,
        ST_DIV_RUN,
        ST_DIV_FIN
    } t_bstate;

endpackage

// ----- src/qlsc_fifo.sv -----
module qlsc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qlsc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output qlsc_pkg::t_item o_item,
    output logic            o_empty
);

    qlsc_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            if (i_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- src/qlsc_front.sv -----
module qlsc_front #(
    parameter int MAX_PAIRS   = 256,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [qlsc_pkg::SAMPLE_W-1:0]  i_x,
    input  logic [qlsc_pkg::SAMPLE_W-1:0]  i_y,
    input  logic [qlsc_pkg::CNT_W-1:0]     i_fit_count,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output qlsc_pkg::t_item                o_item
);

    localparam logic [qlsc_pkg::SAMPLE_W-1:0] SMASK =
        qlsc_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [qlsc_pkg::CNT_W-1:0] LIMIT_MAX = qlsc_pkg::CNT_W'(MAX_PAIRS);

    logic [qlsc_pkg::CNT_W-1:0] r_count;
    logic [qlsc_pkg::CNT_W-1:0] w_limit;
    logic                       w_acc;

    assign w_limit  = (i_fit_count > LIMIT_MAX) ? LIMIT_MAX : i_fit_count;
    assign w_acc    = (r_count < w_limit);
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_item.op = w_acc ? qlsc_pkg::OP_ACCUM : qlsc_pkg::OP_SOLVE;
        o_item.n  = r_count;
        o_item.x  = i_x & SMASK;
        o_item.y  = i_y & SMASK;
    end

    // pair count mirrors what the back end will have summed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_q_push) begin
            r_count <= w_acc ? r_count + 1'b1 : '0;
        end
    end

endmodule

// ----- src/qlsc_back.sv -----
module qlsc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_vld,
    input  qlsc_pkg::t_item              i_item,
    output logic                         o_item_pop,
    input  logic                         i_res_pop,
    output logic                         o_res_vld,
    output logic                         o_collecting,
    output logic                         o_coeffs_valid,
    output logic                         o_singular,
    output logic signed [qlsc_pkg::COEF_W-1:0] o_coeff_constant,
    output logic signed [qlsc_pkg::COEF_W-1:0] o_coeff_linear,
    output logic signed [qlsc_pkg::COEF_W-1:0] o_coeff_square
);

    localparam int W  = qlsc_pkg::WIDE_W;
    localparam int SW = qlsc_pkg::SAMPLE_W;
    localparam int CW = qlsc_pkg::COEF_W;
    localparam int EW = qlsc_pkg::ENT_W;

    qlsc_pkg::t_bstate r_state, n_state;

    logic          r_res_vld, r_collecting, r_coeffs_valid, r_singular;
    logic [CW-1:0] r_c0, r_c1, r_c2;

    logic [SW-1:0]     r_x, r_y;
    logic [2*SW-1:0]   r_x2, r_xy;
    logic [3*SW-1:0]   r_x3, r_x2y;
    logic [4*SW-1:0]   r_x4;
    logic [qlsc_pkg::CNT_W-1:0] r_n;

    logic [qlsc_pkg::SX_W-1:0]   r_sx;
    logic [qlsc_pkg::SX2_W-1:0]  r_sx2;
    logic [qlsc_pkg::SX3_W-1:0]  r_sx3;
    logic [qlsc_pkg::SX4_W-1:0]  r_sx4;
    logic [qlsc_pkg::SY_W-1:0]   r_sy;
    logic [qlsc_pkg::SXY_W-1:0]  r_sxy;
    logic [qlsc_pkg::SX2Y_W-1:0] r_sx2y;

    logic [qlsc_pkg::STEP_W-1:0] r_step;
    logic [1:0]                  r_det_sel;

    logic [W-1:0]  r_ma, r_prod, r_p1, r_m, r_acc, r_det;
    logic [EW-1:0] r_mb;

    logic [W-1:0]  r_dm, r_dd, r_rem;
    logic [CW-1:0] r_q;
    logic          r_qhi, r_neg;
    logic [qlsc_pkg::DCNT_W-1:0] r_dcnt;

    logic [EW-1:0] w_mat [3][3];
    logic [EW-1:0] w_rhs [3];
    logic [EW-1:0] w_e   [3][3];
    logic [W-1:0]  w_ma_ld;
    logic [EW-1:0] w_mb_ld;
    logic          w_mul_done, w_res_set, w_start;
    logic [W-1:0]  w_rem_sh;
    logic          w_ge;
    logic [CW-1:0] w_coef;

    // normal-equation matrix; the column under solve is swapped for the right-hand side
    always_comb begin
        w_mat[0][0] = EW'(r_n);    w_mat[0][1] = EW'(r_sx);  w_mat[0][2] = EW'(r_sx2);
        w_mat[1][0] = EW'(r_sx);   w_mat[1][1] = EW'(r_sx2); w_mat[1][2] = EW'(r_sx3);
        w_mat[2][0] = EW'(r_sx2);  w_mat[2][1] = EW'(r_sx3); w_mat[2][2] = EW'(r_sx4);
        w_rhs[0] = EW'(r_sy);
        w_rhs[1] = EW'(r_sxy);
        w_rhs[2] = EW'(r_sx2y);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_det_sel != 2'd0 && 2'(c) == r_det_sel - 2'd1) w_e[r][c] = w_rhs[r];
                else w_e[r][c] = w_mat[r][c];
            end
        end
    end

    // det = e00(e11e22-e12e21) - e01(e10e22-e12e20) + e02(e10e21-e11e20)
    always_comb begin
        w_ma_ld = '0;
        w_mb_ld = '0;
        case (r_step)
            4'd0: begin w_ma_ld = W'(w_e[1][1]); w_mb_ld = w_e[2][2]; end
            4'd1: begin w_ma_ld = W'(w_e[1][2]); w_mb_ld = w_e[2][1]; end
            4'd2: begin w_ma_ld = r_m;           w_mb_ld = w_e[0][0]; end
            4'd3: begin w_ma_ld = W'(w_e[1][0]); w_mb_ld = w_e[2][2]; end
            4'd4: begin w_ma_ld = W'(w_e[1][2]); w_mb_ld = w_e[2][0]; end
            4'd5: begin w_ma_ld = r_m;           w_mb_ld = w_e[0][1]; end
            4'd6: begin w_ma_ld = W'(w_e[1][0]); w_mb_ld = w_e[2][1]; end
            4'd7: begin w_ma_ld = W'(w_e[1][1]); w_mb_ld = w_e[2][0]; end
            4'd8: begin w_ma_ld = r_m;           w_mb_ld = w_e[0][2]; end
            default: begin w_ma_ld = '0; w_mb_ld = '0; end
        endcase
    end

    assign w_mul_done = (r_mb == '0);
    assign w_rem_sh   = {r_rem[W-2:0], r_dm[W-1]};
    assign w_ge       = (w_rem_sh >= r_dd);

    always_comb begin
        if (r_qhi) w_coef = r_neg ? qlsc_pkg::SAT_MIN : qlsc_pkg::SAT_MAX;
        else if (!r_neg) w_coef = (r_q > qlsc_pkg::SAT_MAX) ? qlsc_pkg::SAT_MAX : r_q;
        else w_coef = (r_q > qlsc_pkg::SAT_MIN) ? qlsc_pkg::SAT_MIN : (~r_q + 1'b1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qlsc_pkg::ST_IDLE: begin
                if (i_item_vld && !r_res_vld) begin
                    n_state = (i_item.op == qlsc_pkg::OP_ACCUM) ? qlsc_pkg::ST_ACC_SQ
                                                                : qlsc_pkg::ST_MUL_LOAD;
                end
            end
            qlsc_pkg::ST_ACC_SQ:   n_state = qlsc_pkg::ST_ACC_CUBE;
            qlsc_pkg::ST_ACC_CUBE: n_state = qlsc_pkg::ST_ACC_SUM;
            qlsc_pkg::ST_ACC_SUM:  n_state = qlsc_pkg::ST_IDLE;
            qlsc_pkg::ST_MUL_LOAD: n_state = qlsc_pkg::ST_MUL_RUN;
            qlsc_pkg::ST_MUL_RUN: begin
                if (w_mul_done) begin
                    n_state = (r_step == qlsc_pkg::LAST_STEP) ? qlsc_pkg::ST_DET_END
                                                              : qlsc_pkg::ST_MUL_LOAD;
                end
            end
            qlsc_pkg::ST_DET_END: begin
                if (r_det_sel != 2'd0) n_state = qlsc_pkg::ST_DIV_ABS;
                else if (r_acc == '0) n_state = qlsc_pkg::ST_IDLE;
                else n_state = qlsc_pkg::ST_MUL_LOAD;
            end
            qlsc_pkg::ST_DIV_ABS:  n_state = qlsc_pkg::ST_DIV_PREP;
            qlsc_pkg::ST_DIV_PREP: n_state = qlsc_pkg::ST_DIV_RUN;
            qlsc_pkg::ST_DIV_RUN: begin
                if (r_dcnt == '0) n_state = qlsc_pkg::ST_DIV_FIN;
            end
            qlsc_pkg::ST_DIV_FIN: begin
                n_state = (r_det_sel == 2'd3) ? qlsc_pkg::ST_IDLE : qlsc_pkg::ST_MUL_LOAD;
            end
            default: n_state = qlsc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_start   = 1'b0;
        w_res_set = 1'b0;
        unique case (r_state)
            qlsc_pkg::ST_IDLE:    w_start   = i_item_vld && !r_res_vld;
            qlsc_pkg::ST_ACC_SUM: w_res_set = 1'b1;
            qlsc_pkg::ST_DET_END: w_res_set = (r_det_sel == 2'd0) && (r_acc == '0);
            qlsc_pkg::ST_DIV_FIN: w_res_set = (r_det_sel == 2'd3);
            default: begin
                w_start   = 1'b0;
                w_res_set = 1'b0;
            end
        endcase
    end

    assign o_item_pop = w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= qlsc_pkg::ST_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_res_set) r_res_vld <= 1'b1;
            else if (i_res_pop) r_res_vld <= 1'b0;
        end
    end

    // running sums; cleared after every solve
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_res_set && r_state != qlsc_pkg::ST_ACC_SUM)) begin
            r_sx   <= '0;
            r_sx2  <= '0;
            r_sx3  <= '0;
            r_sx4  <= '0;
            r_sy   <= '0;
            r_sxy  <= '0;
            r_sx2y <= '0;
        end else if (r_state == qlsc_pkg::ST_ACC_SUM) begin
            r_sx   <= r_sx + qlsc_pkg::SX_W'(r_x);
            r_sx2  <= r_sx2 + qlsc_pkg::SX2_W'(r_x2);
            r_sx3  <= r_sx3 + qlsc_pkg::SX3_W'(r_x3);
            r_sx4  <= r_sx4 + qlsc_pkg::SX4_W'(r_x4);
            r_sy   <= r_sy + qlsc_pkg::SY_W'(r_y);
            r_sxy  <= r_sxy + qlsc_pkg::SXY_W'(r_xy);
            r_sx2y <= r_sx2y + qlsc_pkg::SX2Y_W'(r_x2y);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            qlsc_pkg::ST_IDLE: begin
                if (w_start) begin
                    r_x       <= i_item.x;
                    r_y       <= i_item.y;
                    r_n       <= i_item.n;
                    r_step    <= '0;
                    r_det_sel <= 2'd0;
                end
            end
            qlsc_pkg::ST_ACC_SQ: begin
                r_x2 <= r_x * r_x;
                r_xy <= r_x * r_y;
            end
            qlsc_pkg::ST_ACC_CUBE: begin
                r_x3  <= r_x2 * r_x;
                r_x4  <= r_x2 * r_x2;
                r_x2y <= r_x2 * r_y;
            end
            qlsc_pkg::ST_ACC_SUM: begin
                r_collecting   <= 1'b1;
                r_coeffs_valid <= 1'b0;
                r_singular     <= 1'b0;
                r_c0 <= '0;
                r_c1 <= '0;
                r_c2 <= '0;
            end
            qlsc_pkg::ST_MUL_LOAD: begin
                r_ma   <= w_ma_ld;
                r_mb   <= w_mb_ld;
                r_prod <= '0;
            end
            qlsc_pkg::ST_MUL_RUN: begin
                if (w_mul_done) begin
                    case (r_step) inside
                        4'd0, 4'd3, 4'd6: r_p1  <= r_prod;
                        4'd1, 4'd4, 4'd7: r_m   <= r_p1 - r_prod;
                        4'd2:             r_acc <= r_prod;
                        4'd5:             r_acc <= r_acc - r_prod;
                        4'd8:             r_acc <= r_acc + r_prod;
                        default:          r_p1  <= r_p1;
                    endcase
                    if (r_step != qlsc_pkg::LAST_STEP) r_step <= r_step + 1'b1;
                end else begin
                    if (r_mb[0]) r_prod <= r_prod + r_ma;
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end
            qlsc_pkg::ST_DET_END: begin
                if (r_det_sel == 2'd0) begin
                    r_det     <= r_acc;
                    r_det_sel <= 2'd1;
                    r_step    <= '0;
                    if (r_acc == '0) begin
                        r_collecting   <= 1'b0;
                        r_coeffs_valid <= 1'b0;
                        r_singular     <= 1'b1;
                        r_c0 <= '0;
                        r_c1 <= '0;
                        r_c2 <= '0;
                    end
                end
            end
            qlsc_pkg::ST_DIV_ABS: begin
                r_neg <= r_acc[W-1] ^ r_det[W-1];
                r_dm  <= r_acc[W-1] ? (~r_acc + 1'b1) : r_acc;
                r_dd  <= r_det[W-1] ? (~r_det + 1'b1) : r_det;
            end
            qlsc_pkg::ST_DIV_PREP: begin
                // (2|num|*2^40 + |den|) / (2|den|) rounds half away from zero
                r_dm   <= (r_dm << (qlsc_pkg::FRAC_BITS + 1)) + r_dd;
                r_dd   <= r_dd << 1;
                r_rem  <= '0;
                r_q    <= '0;
                r_qhi  <= 1'b0;
                r_dcnt <= qlsc_pkg::DCNT_W'(W - 1);
            end
            qlsc_pkg::ST_DIV_RUN: begin
                r_rem  <= w_ge ? (w_rem_sh - r_dd) : w_rem_sh;
                r_dm   <= r_dm << 1;
                r_q    <= {r_q[CW-2:0], w_ge};
                r_qhi  <= r_qhi | r_q[CW-1];
                r_dcnt <= r_dcnt - 1'b1;
            end
            qlsc_pkg::ST_DIV_FIN: begin
                case (r_det_sel)
                    2'd1:    r_c0 <= w_coef;
                    2'd2:    r_c1 <= w_coef;
                    default: r_c2 <= w_coef;
                endcase
                r_det_sel <= r_det_sel + 2'd1;
                r_step    <= '0;
                if (r_det_sel == 2'd3) begin
                    r_collecting   <= 1'b0;
                    r_coeffs_valid <= 1'b1;
                    r_singular     <= 1'b0;
                end
            end
            default: r_step <= r_step;
        endcase
    end

    assign o_res_vld        = r_res_vld;
    assign o_collecting     = r_collecting;
    assign o_coeffs_valid   = r_coeffs_valid;
    assign o_singular       = r_singular;
    assign o_coeff_constant = r_c0;
    assign o_coeff_linear   = r_c1;
    assign o_coeff_square   = r_c2;

endmodule

// ----- src/quadratic_least_squares_calibrator.sv -----
// Quadratic least-squares calibrator. Push (x, y) calibration words; each word
// yields exactly one result word. While fewer than fit_sample_count pairs are
// summed, a word passes the back end in two registered multiply stages, then
// the sum update, and returns collecting=1 with zero coefficients.
// The following word triggers the solve instead: up to four 3x3 determinants
// built from up to 36 shift-add multiplies that walk the sum operand bit by bit,
// then three restoring divides. It returns a0, a1, a2 in signed Q24.40 (rounded,
// saturated) or singular=1, then starts a fresh collection. A two-word input
// queue takes words while the back end is busy or a result waits to be popped.
// fit_sample_count sits at APB address 0, reset value 16.
module quadratic_least_squares_calibrator #(
    parameter int MAX_PAIRS   = 256,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [qlsc_pkg::SAMPLE_W-1:0]       i_ref_value,
    input  logic [qlsc_pkg::SAMPLE_W-1:0]       i_measured_value,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_collecting,
    output logic                                o_coeffs_valid,
    output logic                                o_singular,
    output logic signed [qlsc_pkg::COEF_W-1:0]  o_coeff_constant,
    output logic signed [qlsc_pkg::COEF_W-1:0]  o_coeff_linear,
    output logic signed [qlsc_pkg::COEF_W-1:0]  o_coeff_square,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qlsc_pkg::PADDR_W-1:0]        paddr,
    input  logic [qlsc_pkg::PDATA_W-1:0]        pwdata,
    output logic [qlsc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [qlsc_pkg::CNT_W-1:0] r_fit_count;
    logic                       w_q_push, w_q_full, w_q_empty, w_q_pop, w_res_vld;
    qlsc_pkg::t_item            w_item_in, w_item_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_count <= qlsc_pkg::FIT_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == qlsc_pkg::ADDR_FIT_COUNT) begin
            r_fit_count <= pwdata[qlsc_pkg::CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == qlsc_pkg::ADDR_FIT_COUNT) ?
                    qlsc_pkg::PDATA_W'(r_fit_count) : '0;

    qlsc_front #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_x         (i_ref_value),
        .i_y         (i_measured_value),
        .i_fit_count (r_fit_count),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_item      (w_item_in)
    );

    qlsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_item_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_item_out),
        .o_empty (w_q_empty)
    );

    qlsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_vld       (!w_q_empty),
        .i_item           (w_item_out),
        .o_item_pop       (w_q_pop),
        .i_res_pop        (pop),
        .o_res_vld        (w_res_vld),
        .o_collecting     (o_collecting),
        .o_coeffs_valid   (o_coeffs_valid),
        .o_singular       (o_singular),
        .o_coeff_constant (o_coeff_constant),
        .o_coeff_linear   (o_coeff_linear),
        .o_coeff_square   (o_coeff_square)
    );

    assign full  = w_q_full;
    assign empty = !w_res_vld;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> $countones({o_collecting, o_coeffs_valid, o_singular}) == 1)
        else $error("result word carries more or less than one kind");

    a_collect_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_collecting || o_singular)) |->
            (o_coeff_constant == '0 && o_coeff_linear == '0 && o_coeff_square == '0))
        else $error("coefficients not zero on a non-solve word");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> (!w_q_empty && empty))
        else $error("queue read while result pending or queue empty");

endmodule
